// ===== rtl/m3i_pkg.sv =====
`timescale 1ns / 1ps
package m3i_pkg;

  localparam int ELEM_W    = 32;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int COF_W     = PROD_W + 1;
  localparam int DET_W     = COF_W + ELEM_W;
  localparam int MAG_W     = DET_W - 1;
  localparam int CMAG_W    = PROD_W;
  localparam int NHI_W     = CMAG_W + 2;
  localparam int DV_W      = MAG_W + 1;
  localparam int Q_W       = 32;
  localparam int DIV_ST    = Q_W + 1;
  localparam int PRE_ST    = 7;
  localparam int NST       = PRE_ST + DIV_ST + 1;
  localparam int EPS_W     = 16;
  localparam int IN_W      = 9 * ELEM_W;
  localparam int OUT_W     = 10 * Q_W;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [Q_W-1:0] quot_t;

  // other two indices of a 3x3 minor
  function automatic int idx_lo(input int i);
    return (i == 0) ? 1 : 0;
  endfunction

  function automatic int idx_hi(input int i);
    return (i == 2) ? 1 : 2;
  endfunction

endpackage

// ===== rtl/matrix3x3_inverse_top.sv =====
`timescale 1ns / 1ps
// 3x3 matrix inverse, signed Q16.16, adjugate over determinant.
// Input stream: s_axis_* carries one matrix per transaction, elements
// a00..a22 row-major, 32 bits each, a00 in the lowest bits.
// Output stream: m_axis_* carries b00..b22 (row-major) then the determinant
// in tdata, and the singular flag in tuser. Elements are rounded to nearest
// (ties away from zero) and saturated to Q16.16.
// Singular: |det| <= singular_epsilon (unsigned Q0.16); b is all zero, det still out.
// Throughput: one matrix per cycle while m_axis_tready stays high; 7 stages
// of products/cofactors/determinant, then nine restoring dividers (33 stages:
// an overflow check, then one quotient bit per stage), then the output
// register.
// Stalls: each stage advances when it is empty or the next one advances, so
// bubbles close up; s_axis_tready drops only when every stage holds a
// transaction and m_axis_tready is low. Nothing is lost or repeated.
// Reset clears all valid bits and sets singular_epsilon to 1.
// cfg_wr_en writes cfg_wr_data to singular_epsilon; write it only when idle.
module matrix3x3_inverse_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [m3i_pkg::EPS_W-1:0]   cfg_wr_data,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [m3i_pkg::IN_W-1:0]    s_axis_tdata,  // a00,a01,a02,a10,a11,a12,a20,a21,a22
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [m3i_pkg::OUT_W-1:0]   m_axis_tdata,  // b00,b01,b02,b10,b11,b12,b20,b21,b22,det
  output logic [0:0]                  m_axis_tuser   // singular
);
  import m3i_pkg::*;

  logic [EPS_W-1:0] eps;
  logic [NST-1:0]   v;
  logic [NST-1:0]   adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
    end else if (cfg_wr_en) begin
      eps <= cfg_wr_data;
    end
  end

  always_comb begin
    adv[NST-1] = !v[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = v[NST-1];

  elem_t a_in [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        a_in[r][c] = s_axis_tdata[ELEM_W*(3*r+c) +: ELEM_W];
      end
    end
  end

  // stage 1: 2x2 products
  logic signed [PROD_W-1:0] p1 [3][3];
  logic signed [PROD_W-1:0] s1 [3][3];
  elem_t a1 [3];
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int r = 0; r < 3; r++) begin
        a1[r] <= a_in[r][0];
        for (int c = 0; c < 3; c++) begin
          p1[r][c] <= a_in[idx_lo(r)][idx_lo(c)] * a_in[idx_hi(r)][idx_hi(c)];
          s1[r][c] <= a_in[idx_lo(r)][idx_hi(c)] * a_in[idx_hi(r)][idx_lo(c)];
        end
      end
    end
  end

  // stage 2: cofactors
  logic signed [COF_W-1:0] cof2 [3][3];
  elem_t a2 [3];
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int r = 0; r < 3; r++) begin
        a2[r] <= a1[r];
        for (int c = 0; c < 3; c++) begin
          if (((r + c) % 2) == 1) begin
            cof2[r][c] <= {s1[r][c][PROD_W-1], s1[r][c]} - {p1[r][c][PROD_W-1], p1[r][c]};
          end else begin
            cof2[r][c] <= {p1[r][c][PROD_W-1], p1[r][c]} - {s1[r][c][PROD_W-1], s1[r][c]};
          end
        end
      end
    end
  end

  // stage 3: cofactor times first-column element, split in two partial products
  logic signed [COF_W-1:0] pl3 [3];
  logic signed [COF_W-1:0] ph3 [3];
  logic signed [COF_W-1:0] cof3 [3][3];
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      cof3 <= cof2;
      for (int r = 0; r < 3; r++) begin
        pl3[r] <= $signed({1'b0, cof2[r][0][ELEM_W-1:0]}) * a2[r];
        ph3[r] <= $signed(cof2[r][0][COF_W-1:ELEM_W]) * a2[r];
      end
    end
  end

  // stage 4: expansion terms
  logic signed [DET_W-1:0] t4 [3];
  logic signed [COF_W-1:0] cof4 [3][3];
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      cof4 <= cof3;
      for (int r = 0; r < 3; r++) begin
        t4[r] <= $signed({ph3[r], {ELEM_W{1'b0}}})
               + $signed({{ELEM_W{pl3[r][COF_W-1]}}, pl3[r]});
      end
    end
  end

  // stage 5: determinant
  logic signed [DET_W-1:0] det5;
  logic signed [COF_W-1:0] cof5 [3][3];
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      cof5 <= cof4;
      det5 <= t4[0] + t4[1] + t4[2];
    end
  end

  // stage 6: magnitudes, transpose of the cofactors
  logic [MAG_W-1:0]  magd6;
  logic              dneg6;
  logic [CMAG_W-1:0] magc6 [3][3];
  logic              cneg6 [3][3];
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      dneg6 <= det5[DET_W-1];
      magd6 <= det5[DET_W-1] ? MAG_W'(-det5) : det5[MAG_W-1:0];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          cneg6[i][j] <= cof5[j][i][COF_W-1];
          magc6[i][j] <= cof5[j][i][COF_W-1] ? CMAG_W'(-cof5[j][i])
                                             : cof5[j][i][CMAG_W-1:0];
        end
      end
    end
  end

  // stage 7: divider operands, determinant rounding, singular test
  logic [NHI_W-1:0]    nhi7 [3][3];
  logic                bneg7 [3][3];
  logic [DV_W-1:0]     dv7;
  logic [Q_W-1:0]      nlo7;
  logic [MAG_W-Q_W:0]  dr7;
  logic                dneg7;
  logic                sing7;
  logic [MAG_W:0]      dsum6;
  always_comb begin
    dsum6 = {1'b0, magd6} + (MAG_W+1)'(33'h080000000);
  end
  always_ff @(posedge clk) begin
    if (adv[6]) begin
      dv7   <= {magd6, 1'b0};
      nlo7  <= magd6[Q_W-1:0];
      dr7   <= dsum6[MAG_W:Q_W];
      dneg7 <= dneg6;
      sing7 <= (magd6 <= MAG_W'({eps, {Q_W{1'b0}}}));
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          bneg7[i][j] <= cneg6[i][j] ^ dneg6;
          nhi7[i][j]  <= NHI_W'({magc6[i][j], 1'b0}) + NHI_W'(magd6[MAG_W-1:Q_W]);
        end
      end
    end
  end

  // dividers
  quot_t q_d   [3][3];
  logic  ovf_d [3][3];
  logic  neg_d [3][3];
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      m3i_rdiv u_div (
        .clk     (clk),
        .adv     (adv[PRE_ST +: DIV_ST]),
        .nhi     (DV_W'(nhi7[i][j])),
        .dv      (dv7),
        .nlo     (nlo7),
        .neg     (bneg7[i][j]),
        .q       (q_d[i][j]),
        .ovf     (ovf_d[i][j]),
        .neg_out (neg_d[i][j])
      );
    end
  end

  // determinant and flag ride alongside the dividers
  quot_t det_d  [DIV_ST];
  logic  sing_d [DIV_ST];
  quot_t det_sat;
  always_comb begin
    if (!dneg7) begin
      det_sat = (dr7 > $bits(dr7)'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : dr7[Q_W-1:0];
    end else begin
      det_sat = (dr7 > $bits(dr7)'(32'h80000000)) ? 32'h80000000 : -dr7[Q_W-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv[PRE_ST]) begin
      det_d[0]  <= det_sat;
      sing_d[0] <= sing7;
    end
    for (int k = 1; k < DIV_ST; k++) begin
      if (adv[PRE_ST+k]) begin
        det_d[k]  <= det_d[k-1];
        sing_d[k] <= sing_d[k-1];
      end
    end
  end

  // output register
  quot_t b_sat [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (ovf_d[i][j]) begin
          b_sat[i][j] = neg_d[i][j] ? 32'h80000000 : 32'h7FFFFFFF;
        end else if (!neg_d[i][j]) begin
          b_sat[i][j] = (q_d[i][j] > 32'h7FFFFFFF) ? 32'h7FFFFFFF : q_d[i][j];
        end else begin
          b_sat[i][j] = (q_d[i][j] > 32'h80000000) ? 32'h80000000 : -q_d[i][j];
        end
      end
    end
  end

  quot_t b_out [3][3];
  quot_t det_out;
  logic  sing_out;
  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      det_out  <= det_d[DIV_ST-1];
      sing_out <= sing_d[DIV_ST-1];
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          b_out[i][j] <= sing_d[DIV_ST-1] ? '0 : b_sat[i][j];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_axis_tdata[Q_W*(3*i+j) +: Q_W] = b_out[i][j];
      end
    end
    m_axis_tdata[Q_W*9 +: Q_W] = det_out;
  end
  assign m_axis_tuser = sing_out;

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[Q_W*9-1:0] == '0)
    else $error("singular result with nonzero inverse");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while pipeline can advance");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("valid bits not cleared by reset");

endmodule

// ===== rtl/m3i_rdiv.sv =====
`timescale 1ns / 1ps
module m3i_rdiv (
  input  logic                        clk,
  input  logic [m3i_pkg::DIV_ST-1:0]  adv,
  input  logic [m3i_pkg::DV_W-1:0]    nhi,
  input  logic [m3i_pkg::DV_W-1:0]    dv,
  input  logic [m3i_pkg::Q_W-1:0]     nlo,
  input  logic                        neg,
  output logic [m3i_pkg::Q_W-1:0]     q,
  output logic                        ovf,
  output logic                        neg_out
);
  import m3i_pkg::*;

  logic [DV_W-1:0] rem  [DIV_ST];
  logic [DV_W-1:0] dvs  [DIV_ST];
  logic [Q_W-1:0]  lo   [DIV_ST];
  logic [Q_W-1:0]  qq   [DIV_ST];
  logic            ovfs [DIV_ST];
  logic            negs [DIV_ST];

  // stage 0: quotient must fit in Q_W bits
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem[0]  <= nhi;
      dvs[0]  <= dv;
      lo[0]   <= nlo;
      qq[0]   <= '0;
      ovfs[0] <= (nhi >= dv);
      negs[0] <= neg;
    end
  end

  // one restoring step per stage
  for (genvar k = 1; k < DIV_ST; k++) begin : g_step
    logic [DV_W:0] rs;
    logic          ge;
    always_comb begin
      rs = {rem[k-1], lo[k-1][Q_W-1]};
      ge = (rs >= {1'b0, dvs[k-1]});
    end
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem[k]  <= ge ? DV_W'(rs - {1'b0, dvs[k-1]}) : rs[DV_W-1:0];
        dvs[k]  <= dvs[k-1];
        lo[k]   <= {lo[k-1][Q_W-2:0], 1'b0};
        qq[k]   <= {qq[k-1][Q_W-2:0], ge};
        ovfs[k] <= ovfs[k-1];
        negs[k] <= negs[k-1];
      end
    end
  end

  assign q       = qq[DIV_ST-1];
  assign ovf     = ovfs[DIV_ST-1];
  assign neg_out = negs[DIV_ST-1];

endmodule

// ===== tb/tb_matrix3x3_inverse_top.sv =====
`timescale 1ns / 1ps
module tb_matrix3x3_inverse_top;
  import m3i_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    elem_t b [9];
    elem_t det;
    logic  singular;
  } inverse_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [EPS_W-1:0]     cfg_wr_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic [0:0]           m_axis_tuser;

  inverse_t             pending_inverses[$];
  logic [EPS_W-1:0]     eps_model = EPS_RESET;
  int                   error_count = 0;
  int                   matrices_sent = 0;
  int                   inverses_checked = 0;
  int                   singular_seen = 0;
  int                   cycle_count = 0;
  int                   sink_wait = 0;
  bit                   sink_no_stall = 0;
  bit                   src_no_gap = 0;

  matrix3x3_inverse_top DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("%0t timeout", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic elem_t round_sat(input wide_t num, input wide_t den);
    logic  neg;
    wide_t un, ud, q;
    neg = (num < 0) != (den < 0);
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = ((un <<< 1) + ud) / (ud <<< 1);
    if (!neg && q > 128'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (neg && q > 128'sh80000000) return 32'h80000000;
    return neg ? elem_t'(-q) : elem_t'(q);
  endfunction

  function automatic inverse_t compute_inverse(input elem_t a [9]);
    inverse_t res;
    wide_t    cof [3][3];
    wide_t    det, mag, dr;
    int       r1, r2, c1, c2;
    det = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        r1 = (r == 0) ? 1 : 0;
        r2 = (r == 2) ? 1 : 2;
        c1 = (c == 0) ? 1 : 0;
        c2 = (c == 2) ? 1 : 2;
        cof[r][c] = wide_t'(a[r1*3+c1]) * wide_t'(a[r2*3+c2])
                  - wide_t'(a[r1*3+c2]) * wide_t'(a[r2*3+c1]);
        if ((r + c) % 2 == 1) cof[r][c] = -cof[r][c];
      end
    end
    for (int r = 0; r < 3; r++) det += cof[r][0] * wide_t'(a[r*3]);
    mag = (det < 0) ? -det : det;
    res.singular = mag <= (wide_t'(eps_model) <<< 32);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        res.b[r*3+c] = res.singular ? elem_t'(0) : round_sat(cof[c][r] <<< 32, det);
    dr = (mag + 128'sh80000000) >>> 32;
    if (det < 0) dr = -dr;
    if (dr > 128'sh7FFFFFFF) res.det = 32'h7FFFFFFF;
    else if (dr < -128'sh80000000) res.det = 32'h80000000;
    else res.det = elem_t'(dr);
    return res;
  endfunction

  task automatic send_matrix(input elem_t a [9]);
    int              gap;
    logic            ready_seen;
    logic [IN_W-1:0] packed_a;
    gap = src_no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) packed_a[32*i +: 32] = a[i];
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= packed_a;
    do begin
      @(negedge clk);
      ready_seen = s_axis_tready;
      @(posedge clk);
    end while (!ready_seen);
    pending_inverses.push_back(compute_inverse(a));
    matrices_sent++;
  endtask

  task automatic idle_source();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_pipeline();
    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_epsilon(input logic [EPS_W-1:0] value);
    idle_source();
    drain_pipeline();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    eps_model = value;
  endtask

  function automatic elem_t small_value();
    return elem_t'($urandom_range(0, 32'h7FFFF)) - 32'sh40000;
  endfunction

  task automatic send_diag(input elem_t d0, input elem_t d1, input elem_t d2);
    elem_t a [9];
    foreach (a[i]) a[i] = 0;
    a[0] = d0;
    a[4] = d1;
    a[8] = d2;
    send_matrix(a);
  endtask

  task automatic send_fill(input elem_t v);
    elem_t a [9];
    foreach (a[i]) a[i] = v;
    send_matrix(a);
  endtask

  task automatic send_random(input int kind);
    elem_t a [9];
    case (kind)
      0: begin
        foreach (a[i]) a[i] = $urandom;
      end
      1: begin
        foreach (a[i]) a[i] = small_value();
      end
      2: begin
        foreach (a[i]) a[i] = small_value();
        for (int c = 0; c < 3; c++) a[6+c] = a[c];
      end
      default: begin
        foreach (a[i]) a[i] = elem_t'($urandom_range(0, 32'h3FF)) - 32'sh200;
        for (int i = 0; i < 3; i++) a[i*4] = small_value() | 32'sh10000;
      end
    endcase
    send_matrix(a);
  endtask

  task automatic test_directed();
    elem_t a [9];
    send_diag(32'sh10000, 32'sh10000, 32'sh10000);
    send_diag(32'sh20000, -32'sh8000, 32'sh30000);
    send_fill(32'sh0);
    send_fill(32'sh7FFFFFFF);
    send_fill(32'sh80000000);
    send_fill(-32'sh1);
    send_diag(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_diag(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_diag(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
    send_diag(32'sh1, 32'sh10000, 32'sh10000);
    send_diag(32'sh10000, 32'sh10000, 32'sh1);
    send_diag(32'sh10000, 32'sh10000, 32'sh2);
    send_diag(32'sh10000, 32'sh10000, -32'sh2);
    send_diag(32'sh3, 32'sh3, 32'sh3);
    a = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000,
          32'sh60000, 32'sh70000, 32'sh80000, 32'sh9A000};
    send_matrix(a);
    a = '{32'sh0, 32'sh10000, 32'sh0, 32'sh0, 32'sh0, 32'sh10000,
          32'sh10000, 32'sh0, 32'sh0};
    send_matrix(a);
    a = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
          32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFE};
    send_matrix(a);
    a = '{32'sh18000, 32'sh0, 32'sh0, 32'sh0, 32'sh18000, 32'sh0,
          32'sh0, 32'sh0, 32'sh18000};
    send_matrix(a);
    idle_source();
  endtask

  task automatic test_epsilon_limits();
    logic [EPS_W-1:0] eps_list [4] = '{16'h0, 16'hFFFF, 16'h1234, 16'h8000};
    foreach (eps_list[k]) begin
      write_epsilon(eps_list[k]);
      send_diag(32'sh10000, 32'sh10000, elem_t'(eps_list[k]));
      send_diag(32'sh10000, 32'sh10000, elem_t'(eps_list[k]) + 1);
      send_diag(32'sh10000, 32'sh10000, -elem_t'(eps_list[k]) - 1);
      send_fill(32'sh0);
      repeat (6) send_random($urandom_range(0, 3));
      idle_source();
    end
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        write_epsilon((i % 400 == 0) ? EPS_W'($urandom) : EPS_W'($urandom_range(0, 15)));
        src_no_gap = ($urandom_range(0, 2) == 0);
        sink_no_stall = ($urandom_range(0, 2) == 0);
      end
      send_random($urandom_range(0, 3));
    end
    idle_source();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      sink_wait = sink_no_stall ? 0 : $urandom_range(0, 9);
      m_axis_tready <= (sink_wait == 0);
    end else if (sink_wait > 0) begin
      sink_wait--;
      m_axis_tready <= (sink_wait == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    inverse_t exp_inv;
    elem_t    got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_inverses.size() == 0) begin
        $display("%0t unexpected transaction tdata=%h", $time, m_axis_tdata);
        error_count++;
      end else begin
        exp_inv = pending_inverses.pop_front();
        inverses_checked++;
        if (exp_inv.singular) singular_seen++;
        for (int i = 0; i < 9; i++) begin
          got = m_axis_tdata[32*i +: 32];
          if (got !== exp_inv.b[i]) begin
            $display("%0t b%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                     exp_inv.b[i], got);
            error_count++;
          end
        end
        if (m_axis_tdata[288 +: 32] !== exp_inv.det) begin
          $display("%0t det expected %h actual %h", $time, exp_inv.det,
                   m_axis_tdata[288 +: 32]);
          error_count++;
        end
        if (m_axis_tuser[0] !== exp_inv.singular) begin
          $display("%0t singular expected %b actual %b", $time, exp_inv.singular,
                   m_axis_tuser[0]);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_epsilon_limits();
    test_random(850);
    write_epsilon(EPS_RESET);
    drain_pipeline();
    $display("Checked %0d of %0d matrices (%0d singular) over epsilon extremes,",
             inverses_checked, matrices_sent, singular_seen);
    $display("saturating inputs and random source gaps and sink stalls.");
    if (error_count == 0 && pending_inverses.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
